// ===== design/pcrl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the per-client request limiter.
// Shared widths, reset values, codes, and controller/datapath types. No dependencies.
package pcrl_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned MINUTE_W   = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STATUS_W   = 2;

  // Input operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTES_PER_DAY = 2'd2;

  // Configuration reset values
  localparam logic [COUNT_W-1:0]  DAY_LIMIT_RST       = 16'd2000;
  localparam logic [COUNT_W-1:0]  MINUTE_LIMIT_RST    = 16'd30;
  localparam logic [MINUTE_W-1:0] MINUTES_PER_DAY_RST = 11'd1440;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Result status codes
  localparam logic [STATUS_W-1:0] RES_GRANTED    = 2'd0;
  localparam logic [STATUS_W-1:0] RES_OVER_LIMIT = 2'd1;
  localparam logic [STATUS_W-1:0] RES_TABLE_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] RES_TICK_DONE  = 2'd3;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_SWEEP,
    WR_COMMIT
  } wr_mode_e;

  typedef enum logic [2:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_SCAN,
    CTL_DECIDE,
    CTL_SWEEP,
    CTL_TICK_END
  } ctl_state_e;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    logic     idx_inc;
    logic     scan;
    wr_mode_e wr_mode;
    logic     load_out;
    logic     res_tick;
  } pcrl_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic hit;
    logic last_eval;
    logic all_issued;
    logic idx_last;
  } pcrl_sts_t;

endpackage

// ===== design/pcrl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request limiter: request in, result out.
// Depends on pcrl_pkg for field widths.
interface pcrl_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [pcrl_pkg::ADDR_W-1:0] client_address;

  modport source (output valid, output operation, output client_address, input ready);
  modport sink   (input valid, input operation, input client_address, output ready);
endinterface

interface pcrl_res_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [pcrl_pkg::STATUS_W-1:0] status;

  modport source (output valid, output granted, output status, input ready);
  modport sink   (input valid, input granted, input status, output ready);
endinterface

// ===== design/pcrl_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: client table memories, scan pipeline, minute counter, config and result registers.
// Depends on pcrl_pkg; driven by pcrl_ctrl through pcrl_cmd_t.
module pcrl_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcrl_pkg::pcrl_cmd_t               cmd_i,
  output pcrl_pkg::pcrl_sts_t               sts_o,
  input  logic                              in_operation_i,
  input  logic [pcrl_pkg::ADDR_W-1:0]       in_client_address_i,
  input  logic                              cfg_we_i,
  input  logic [pcrl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcrl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              res_granted_o,
  output logic [pcrl_pkg::STATUS_W-1:0]     res_status_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  // Table storage
  logic                          valid_mem [TABLE_ENTRIES];
  logic [pcrl_pkg::ADDR_W-1:0]   addr_mem  [TABLE_ENTRIES];
  logic [pcrl_pkg::COUNT_W-1:0]  day_mem   [TABLE_ENTRIES];
  logic [pcrl_pkg::COUNT_W-1:0]  min_mem   [TABLE_ENTRIES];

  // Configuration
  logic [pcrl_pkg::COUNT_W-1:0]  day_lim_q, min_lim_q;
  logic [pcrl_pkg::MINUTE_W-1:0] mpd_q;

  // Item and scan state
  logic [CW-1:0]                 idx_q;
  logic [pcrl_pkg::ADDR_W-1:0]   addr_q;
  logic                          rd_vld_q;
  logic [IW-1:0]                 rd_idx_q;
  logic                          rd_valid_q;
  logic [pcrl_pkg::ADDR_W-1:0]   rd_addr_q;
  logic [pcrl_pkg::COUNT_W-1:0]  rd_day_q, rd_min_q;
  logic                          hit_q, free_q;
  logic [IW-1:0]                 slot_idx_q;
  logic [pcrl_pkg::COUNT_W-1:0]  slot_day_q, slot_min_q;
  logic [pcrl_pkg::MINUTE_W-1:0] minutes_q, minutes_d;
  logic                          clear_all_q;
  logic                          res_granted_q;
  logic [pcrl_pkg::STATUS_W-1:0] res_status_q;

  logic                          hit;
  logic                          found, over, grant;
  logic [pcrl_pkg::STATUS_W-1:0] req_status;
  logic [pcrl_pkg::COUNT_W-1:0]  day_inc, min_inc;

  // Write port
  logic                          valid_we, addr_we, day_we, min_we;
  logic                          valid_wd;
  logic [pcrl_pkg::COUNT_W-1:0]  day_wd, min_wd;
  logic [IW-1:0]                 wr_idx;

  assign hit = rd_vld_q && rd_valid_q && (rd_addr_q == addr_q);

  assign sts_o.in_tick    = (in_operation_i == pcrl_pkg::OP_TICK);
  assign sts_o.hit        = hit;
  assign sts_o.last_eval  = rd_vld_q && (rd_idx_q == IW'(TABLE_ENTRIES - 1));
  assign sts_o.all_issued = (idx_q == CW'(TABLE_ENTRIES));
  assign sts_o.idx_last   = (idx_q == CW'(TABLE_ENTRIES - 1));

  // Free slot carries zero counts, so it can never be over a limit
  assign found   = hit_q || free_q;
  assign over    = (slot_day_q > day_lim_q) || (slot_min_q > min_lim_q);
  assign grant   = found && !over;
  assign day_inc = (slot_day_q == pcrl_pkg::COUNT_MAX) ? slot_day_q : slot_day_q + 1'b1;
  assign min_inc = (slot_min_q == pcrl_pkg::COUNT_MAX) ? slot_min_q : slot_min_q + 1'b1;

  always_comb begin
    if (!found) begin
      req_status = pcrl_pkg::RES_TABLE_FULL;
    end else if (over) begin
      req_status = pcrl_pkg::RES_OVER_LIMIT;
    end else begin
      req_status = pcrl_pkg::RES_GRANTED;
    end
  end

  always_comb begin
    valid_we = 1'b0;
    addr_we  = 1'b0;
    day_we   = 1'b0;
    min_we   = 1'b0;
    valid_wd = 1'b0;
    day_wd   = day_inc;
    min_wd   = min_inc;
    wr_idx   = idx_q[IW-1:0];
    unique case (cmd_i.wr_mode)
      pcrl_pkg::WR_NONE: begin
      end
      pcrl_pkg::WR_CLEAR: begin
        valid_we = 1'b1;
      end
      pcrl_pkg::WR_SWEEP: begin
        min_we   = 1'b1;
        min_wd   = '0;
        valid_we = clear_all_q;
      end
      pcrl_pkg::WR_COMMIT: begin
        valid_we = grant;
        addr_we  = grant;
        day_we   = grant;
        min_we   = grant;
        valid_wd = 1'b1;
        wr_idx   = slot_idx_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (valid_we) begin
      valid_mem[wr_idx] <= valid_wd;
    end
    if (cmd_i.rd_en) begin
      rd_valid_q <= valid_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[wr_idx] <= addr_q;
    end
    if (cmd_i.rd_en) begin
      rd_addr_q <= addr_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (day_we) begin
      day_mem[wr_idx] <= day_wd;
    end
    if (cmd_i.rd_en) begin
      rd_day_q <= day_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (min_we) begin
      min_mem[wr_idx] <= min_wd;
    end
    if (cmd_i.rd_en) begin
      rd_min_q <= min_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_lim_q <= pcrl_pkg::DAY_LIMIT_RST;
      min_lim_q <= pcrl_pkg::MINUTE_LIMIT_RST;
      mpd_q     <= pcrl_pkg::MINUTES_PER_DAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcrl_pkg::CFG_DAY_LIMIT:       day_lim_q <= cfg_data_i;
        pcrl_pkg::CFG_MINUTE_LIMIT:    min_lim_q <= cfg_data_i;
        pcrl_pkg::CFG_MINUTES_PER_DAY: mpd_q     <= cfg_data_i[pcrl_pkg::MINUTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign minutes_d = minutes_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      minutes_q   <= '0;
      clear_all_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.accept) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        if (in_operation_i == pcrl_pkg::OP_TICK) begin
          // minutes_per_day of zero clears on every tick
          if (minutes_d >= mpd_q) begin
            minutes_q   <= '0;
            clear_all_q <= 1'b1;
          end else begin
            minutes_q   <= minutes_d;
            clear_all_q <= 1'b0;
          end
        end
      end else begin
        if (cmd_i.idx_inc) begin
          idx_q <= idx_q + 1'b1;
        end
        if (cmd_i.scan && hit) begin
          hit_q <= 1'b1;
        end else if (cmd_i.scan && rd_vld_q && !rd_valid_q && !free_q && !hit_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // Slot payload follows the flag updates above
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= in_client_address_i;
    end
    if (cmd_i.scan && hit) begin
      slot_idx_q <= rd_idx_q;
      slot_day_q <= rd_day_q;
      slot_min_q <= rd_min_q;
    end else if (cmd_i.scan && rd_vld_q && !rd_valid_q && !free_q && !hit_q) begin
      slot_idx_q <= rd_idx_q;
      slot_day_q <= '0;
      slot_min_q <= '0;
    end
    if (cmd_i.rd_en) begin
      rd_idx_q <= idx_q[IW-1:0];
    end
    if (cmd_i.load_out) begin
      res_granted_q <= cmd_i.res_tick ? 1'b0 : grant;
      res_status_q  <= cmd_i.res_tick ? pcrl_pkg::RES_TICK_DONE : req_status;
    end
  end

  assign res_granted_o = res_granted_q;
  assign res_status_o  = res_status_q;

endmodule

// ===== design/pcrl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller FSM: table clear after reset, request scan/decide, tick sweep, output handshake.
// Depends on pcrl_pkg; drives pcrl_datapath through pcrl_cmd_t.
module pcrl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pcrl_pkg::pcrl_sts_t sts_i,
  output pcrl_pkg::pcrl_cmd_t cmd_o
);

  pcrl_pkg::ctl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  // Result slot can take a new value when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcrl_pkg::CTL_CLEAR: begin
        if (sts_i.idx_last) state_d = pcrl_pkg::CTL_IDLE;
      end
      pcrl_pkg::CTL_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_tick ? pcrl_pkg::CTL_SWEEP : pcrl_pkg::CTL_SCAN;
        end
      end
      pcrl_pkg::CTL_SCAN: begin
        if (sts_i.hit || sts_i.last_eval) state_d = pcrl_pkg::CTL_DECIDE;
      end
      pcrl_pkg::CTL_DECIDE: begin
        if (out_free) state_d = pcrl_pkg::CTL_IDLE;
      end
      pcrl_pkg::CTL_SWEEP: begin
        if (sts_i.idx_last) state_d = pcrl_pkg::CTL_TICK_END;
      end
      pcrl_pkg::CTL_TICK_END: begin
        if (out_free) state_d = pcrl_pkg::CTL_IDLE;
      end
      default: state_d = pcrl_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pcrl_pkg::CTL_CLEAR: begin
        cmd_o.wr_mode = pcrl_pkg::WR_CLEAR;
        cmd_o.idx_inc = 1'b1;
      end
      pcrl_pkg::CTL_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      pcrl_pkg::CTL_SCAN: begin
        cmd_o.rd_en   = !sts_i.all_issued;
        cmd_o.idx_inc = !sts_i.all_issued;
        cmd_o.scan    = 1'b1;
      end
      pcrl_pkg::CTL_DECIDE: begin
        if (out_free) begin
          cmd_o.wr_mode  = pcrl_pkg::WR_COMMIT;
          cmd_o.load_out = 1'b1;
        end
      end
      pcrl_pkg::CTL_SWEEP: begin
        cmd_o.wr_mode = pcrl_pkg::WR_SWEEP;
        cmd_o.idx_inc = 1'b1;
      end
      pcrl_pkg::CTL_TICK_END: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_tick = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcrl_pkg::CTL_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/per_client_request_limiter.sv =====
`timescale 1ns / 1ps
// Per-client fixed-window request limiter, top level.
// Depends on pcrl_pkg, pcrl_req_if/pcrl_res_if, pcrl_ctrl and pcrl_datapath.
//
// Each item is handled alone, and the table memory is scanned one entry per cycle through a
// registered read port. A request scan stops at the first hit or after the last entry; a minute
// tick sweeps every entry. The result register decouples the output: a new item is taken while
// the previous result waits. After reset the block invalidates every table entry before its
// first input transfer; configuration writes are taken at any time and should only be issued
// while the block is idle.
module per_client_request_limiter #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pcrl_req_if.sink                        req_i,
  pcrl_res_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [pcrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcrl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pcrl_pkg::pcrl_cmd_t cmd;
  pcrl_pkg::pcrl_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  pcrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcrl_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_operation_i      (req_i.operation),
    .in_client_address_i (req_i.client_address),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .res_granted_o       (res_o.granted),
    .res_status_o        (res_o.status)
  );

  assign req_i.ready = in_ready;
  assign res_o.valid = out_valid;

endmodule

// ===== design/pcrl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the request limiter, bound to the top level.
// Depends on pcrl_pkg and per_client_request_limiter.
module pcrl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_granted_i,
  input logic [pcrl_pkg::STATUS_W-1:0] out_status_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Items taken but whose result has not been transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_granted_i)
                                    && $stable(out_status_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result without a pending item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two items pending");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && pending_q == 2'd0 |=> !out_valid_i)
    else $error("result appeared one cycle after transfer");

endmodule

bind per_client_request_limiter pcrl_checker u_pcrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_granted_i (res_o.granted),
  .out_status_i  (res_o.status)
);
